// ----- hdl/bfb_pkg.sv -----
// Shared types and constants for the best-fit bin placement block.
package bfb_pkg;

	localparam logic [15:0] CAP_RESET = 16'd100;

	localparam logic FUNC_PLACE   = 1'b0;
	localparam logic FUNC_RESTART = 1'b1;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_OVERSIZE = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;

	typedef logic [15:0] size_t;

	typedef struct packed {
		logic [6:0] bins_open;
		size_t      space_left;
		logic       opened_new;
		logic [5:0] bin_index;
	} result_t;

endpackage

// ----- hdl/best_fit_bin_placement_top.sv -----
// Top level of the best-fit bin placement block: sequencer, scan unit and free-space table.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes bin_capacity; always ready.
//   Write it only while the block is idle. It affects bins opened later and restarts.
//   Input stream s_axis: tuser = func (0 place, 1 restart), tdata = item_size.
//   Output stream m_axis: one transfer per input transfer, tuser = status.
// Operation:
//   The block takes no new item until it is done with the last one. The free-space
//   table is read one bin per cycle through the single read port of the table RAM,
//   and one shared subtract/compare unit tests each bin against the best so far.
//   A restart skips the scan.
// Reset:
//   arst_n clears the packing to one open bin of capacity 100 and sets
//   bin_capacity to 100. No clearing pass is needed.
// Stalls:
//   The result sits in an output register. If m_axis_tready is low, the next
//   item is still scanned but its result waits until the register drains.
module best_fit_bin_placement_top
	import bfb_pkg::*;
#(
	parameter int MAX_BINS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] item_size
	input  logic        s_axis_tuser,   // [0] func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [5:0] bin_index, [6] opened_new,
	                                    // [22:7] space_left, [29:23] bins_open, [31:30] zero
	output logic [1:0]  m_axis_tuser    // [1:0] status
);

	localparam int IW = $clog2(MAX_BINS);
	localparam int CW = $clog2(MAX_BINS + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;

	logic [1:0]    state_q;
	logic [15:0]   cap_q;
	logic          func_q;
	size_t         size_q;
	logic [CW-1:0] open_q;
	logic [CW-1:0] issue_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic [16:0]   best_q;
	logic [IW-1:0] best_idx_q;
	logic          found_q;
	logic          v0_q;

	logic          out_vld_q;
	result_t       out_q;
	logic [1:0]    out_stat_q;

	logic          rd_en;
	logic [15:0]   rd_data;
	logic [15:0]   free_rd;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [15:0]   wr_data;

	logic [15:0]   alu_a;
	logic [16:0]   alu_sub;
	logic          alu_borrow;
	logic          take;
	logic          out_free;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {2'b00, out_q};
	assign m_axis_tuser  = out_stat_q;
	assign out_free      = !out_vld_q || m_axis_tready;

	assign rd_en   = (state_q == ST_SCAN) && (issue_q < open_q);
	assign free_rd = (idx_s1 == '0 && !v0_q) ? CAP_RESET : rd_data;

	// shared subtract/compare unit
	assign alu_a      = (state_q == ST_SCAN) ? free_rd : cap_q;
	assign alu_sub    = {1'b0, alu_a} - {1'b0, size_q};
	assign alu_borrow = alu_sub[16];
	assign take       = vld_s1 && !alu_borrow && ({1'b0, alu_sub[15:0]} <= best_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = alu_sub[15:0];
		if (state_q == ST_DECIDE && out_free) begin
			if (func_q == FUNC_RESTART) begin
				wr_en   = 1'b1;
				wr_data = cap_q;
			end else if (found_q) begin
				wr_en   = 1'b1;
				wr_addr = best_idx_q;
				wr_data = best_q[15:0];
			end else if (!alu_borrow && open_q < CW'(MAX_BINS)) begin
				wr_en   = 1'b1;
				wr_addr = open_q[IW-1:0];
			end
		end
	end

	bfb_ram #(
		.WIDTH(16),
		.DEPTH(MAX_BINS)
	) u_free (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(issue_q[IW-1:0]),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			open_q     <= CW'(1);
			v0_q       <= 1'b0;
			issue_q    <= '0;
			vld_s1     <= 1'b0;
			found_q    <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (out_vld_q && m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						issue_q <= '0;
						vld_s1  <= 1'b0;
						found_q <= 1'b0;
						state_q <= (s_axis_tuser == FUNC_RESTART) ? ST_DECIDE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					vld_s1 <= rd_en;
					if (rd_en) begin
						issue_q <= issue_q + CW'(1);
					end
					if (take) begin
						found_q <= 1'b1;
					end
					if (!rd_en && !vld_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
						if (func_q == FUNC_RESTART) begin
							open_q <= CW'(1);
							v0_q   <= 1'b1;
						end else if (found_q) begin
							if (best_idx_q == '0) begin
								v0_q <= 1'b1;
							end
						end else if (!alu_borrow && open_q < CW'(MAX_BINS)) begin
							open_q <= open_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			func_q <= s_axis_tuser;
			size_q <= s_axis_tdata;
			best_q <= {1'b0, cap_q} + 17'd1;
		end
		if (state_q == ST_SCAN) begin
			idx_s1 <= issue_q[IW-1:0];
			if (take) begin
				best_q     <= {1'b0, alu_sub[15:0]};
				best_idx_q <= idx_s1;
			end
		end
		if (state_q == ST_DECIDE && out_free) begin
			out_q.opened_new <= 1'b0;
			out_q.bin_index  <= '0;
			out_q.space_left <= '0;
			out_q.bins_open  <= 7'(open_q);
			out_stat_q       <= STAT_OK;
			if (func_q == FUNC_RESTART) begin
				out_q.space_left <= cap_q;
				out_q.bins_open  <= 7'd1;
			end else if (found_q) begin
				out_q.bin_index  <= 6'(best_idx_q);
				out_q.space_left <= best_q[15:0];
			end else if (alu_borrow) begin
				out_stat_q <= STAT_OVERSIZE;
			end else if (open_q >= CW'(MAX_BINS)) begin
				out_stat_q <= STAT_FULL;
			end else begin
				out_q.bin_index  <= 6'(open_q);
				out_q.opened_new <= 1'b1;
				out_q.space_left <= alu_sub[15:0];
				out_q.bins_open  <= 7'(open_q + CW'(1));
			end
		end
	end

endmodule

// ----- hdl/bfb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bfb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hdl/bfb_checker.sv -----
// Port-level checker for the best-fit bin placement block, with its bind.
module bfb_checker
	import bfb_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in progress");

	a_error_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != STAT_OK |->
		m_axis_tdata[22:0] == 23'd0)
		else $error("error result carries a placement");

	a_new_bin_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[6] |->
		m_axis_tuser == STAT_OK && m_axis_tdata[5:0] == 6'(m_axis_tdata[29:23] - 7'd1))
		else $error("new bin index does not match bin count");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind best_fit_bin_placement_top bfb_checker u_bfb_checker (.*);

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// Testbench for best_fit_bin_placement_top: directed and sorted random packing runs checked against a predictor.
module tb;
	import bfb_pkg::*;

	localparam int NUM_BINS    = 64;
	localparam int CYCLE_LIMIT = 600000;
	localparam int STALL_LEN   = 400;

	typedef struct packed {
		logic  func;
		size_t size;
	} bin_item_t;

	typedef struct {
		result_t    res;
		logic [1:0] status;
	} placement_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // [15:0] item_size
	logic        s_axis_tuser = 1'b0; // [0] func
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // [5:0] bin_index, [6] opened_new, [22:7] space_left,
	                                  // [29:23] bins_open, [31:30] zero
	logic [1:0]  m_axis_tuser;        // [1:0] status

	bin_item_t  pending_items[$];
	placement_t expected_placements[$];

	size_t bin_room[NUM_BINS];
	int    bins_in_use = 1;
	size_t capacity_now = CAP_RESET;

	bit        calm = 1'b0;
	bit        stall_req = 1'b0;
	int        stall_left = 0;
	int        errors = 0;
	int        cycles = 0;
	bin_item_t next_item;
	result_t   got;
	placement_t want;
	placement_t predicted;

	best_fit_bin_placement_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic placement_t predict_placement(logic func, size_t size);
		placement_t r;
		int best_left;
		int best_bin;
		bit found;
		int b;
		r.res = '0;
		r.status = STAT_OK;
		if (func == FUNC_RESTART) begin
			bins_in_use = 1;
			bin_room[0] = capacity_now;
			r.res.space_left = capacity_now;
			r.res.bins_open = 7'd1;
			return r;
		end
		best_left = int'(capacity_now) + 1;
		best_bin = 0;
		found = 1'b0;
		for (b = 0; b < bins_in_use; b++) begin
			if (size <= bin_room[b] && int'(bin_room[b]) - int'(size) <= best_left) begin
				best_left = int'(bin_room[b]) - int'(size);
				best_bin = b;
				found = 1'b1;
			end
		end
		if (found) begin
			bin_room[best_bin] = size_t'(best_left);
			r.res.bin_index = best_bin[5:0];
			r.res.space_left = size_t'(best_left);
			r.res.bins_open = bins_in_use[6:0];
		end else if (size > capacity_now) begin
			r.res.bins_open = bins_in_use[6:0];
			r.status = STAT_OVERSIZE;
		end else if (bins_in_use >= NUM_BINS) begin
			r.res.bins_open = bins_in_use[6:0];
			r.status = STAT_FULL;
		end else begin
			bin_room[bins_in_use] = capacity_now - size;
			r.res.bin_index = bins_in_use[5:0];
			r.res.opened_new = 1'b1;
			r.res.space_left = capacity_now - size;
			bins_in_use++;
			r.res.bins_open = bins_in_use[6:0];
		end
		return r;
	endfunction

	task automatic log_mismatch(string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	task automatic queue_item(logic func, size_t size);
		bin_item_t it;
		it.func = func;
		it.size = size;
		pending_items = {pending_items, it};
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || s_axis_tvalid || expected_placements.size() != 0)
			@(posedge clk);
		repeat (NUM_BINS + 8) @(posedge clk);
	endtask

	task automatic write_capacity(size_t value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		capacity_now = value;
		@(negedge clk);
	endtask

	task automatic pack_sorted_run(int cap, int count);
		int sizes[$];
		int lo;
		int i;
		lo = ($urandom_range(3) == 0) ? 0 : cap / 3;
		for (i = 0; i < count; i++)
			sizes = {sizes, int'($urandom_range(cap, lo))};
		sizes.rsort();
		queue_item(FUNC_RESTART, size_t'($urandom));
		foreach (sizes[k]) begin
			if ($urandom_range(99) < 8) begin
				case ($urandom_range(2))
					0: queue_item(FUNC_RESTART, size_t'($urandom));
					1: queue_item(FUNC_PLACE, size_t'($urandom));
					default: queue_item(FUNC_PLACE, size_t'($urandom_range(65535, cap)));
				endcase
			end else begin
				queue_item(FUNC_PLACE, size_t'(sizes[k]));
			end
		end
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= FUNC_PLACE;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predicted = predict_placement(s_axis_tuser, s_axis_tdata);
				expected_placements = {expected_placements, predicted};
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
					next_item = pending_items.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= next_item.size;
					s_axis_tuser <= next_item.func;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// hold off the output side for a long stretch on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left <= 0;
		end else if (stall_req) begin
			stall_left <= STALL_LEN;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end
	end

	// output monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_placements.size() == 0) begin
					log_mismatch($sformatf("result transfer with none expected: data %h status %0d",
						m_axis_tdata, m_axis_tuser));
				end else begin
					want = expected_placements.pop_front();
					got = result_t'(m_axis_tdata[29:0]);
					if (got.bin_index !== want.res.bin_index)
						log_mismatch($sformatf("bin_index %0d, expected %0d",
							got.bin_index, want.res.bin_index));
					if (got.opened_new !== want.res.opened_new)
						log_mismatch($sformatf("opened_new %0b, expected %0b",
							got.opened_new, want.res.opened_new));
					if (got.space_left !== want.res.space_left)
						log_mismatch($sformatf("space_left %0d, expected %0d",
							got.space_left, want.res.space_left));
					if (got.bins_open !== want.res.bins_open)
						log_mismatch($sformatf("bins_open %0d, expected %0d",
							got.bins_open, want.res.bins_open));
					if (m_axis_tuser !== want.status)
						log_mismatch($sformatf("status %0d, expected %0d",
							m_axis_tuser, want.status));
				end
			end
			m_axis_tready <= (stall_left == 0) && (calm || $urandom_range(99) >= 28);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL best_fit_bin_placement_top");
			$finish;
		end
	end

	initial begin
		int caps[8];
		int p;
		bin_room[0] = CAP_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// capacity 100 from reset: ties, exact fits, oversize
		queue_item(FUNC_PLACE, 16'd0);
		queue_item(FUNC_PLACE, 16'd60);
		queue_item(FUNC_PLACE, 16'd60);
		queue_item(FUNC_PLACE, 16'd10);
		queue_item(FUNC_PLACE, 16'd101);
		queue_item(FUNC_PLACE, 16'hFFFF);
		queue_item(FUNC_PLACE, 16'd100);
		queue_item(FUNC_PLACE, 16'd30);
		queue_item(FUNC_RESTART, 16'hFFFF);
		queue_item(FUNC_PLACE, 16'd0);

		write_capacity(16'hFFFF);
		queue_item(FUNC_RESTART, 16'd0);
		queue_item(FUNC_PLACE, 16'hFFFF);
		queue_item(FUNC_PLACE, 16'h8000);
		queue_item(FUNC_PLACE, 16'h7FFF);
		queue_item(FUNC_PLACE, 16'd1000);

		// shrink capacity with bins still holding more room than the new capacity
		write_capacity(16'd100);
		queue_item(FUNC_PLACE, 16'd50000);
		queue_item(FUNC_PLACE, 16'd50);
		queue_item(FUNC_PLACE, 16'd5000);
		queue_item(FUNC_RESTART, 16'h5555);

		write_capacity(16'd1);
		queue_item(FUNC_RESTART, 16'hAAAA);
		queue_item(FUNC_PLACE, 16'd1);
		queue_item(FUNC_PLACE, 16'd2);
		queue_item(FUNC_PLACE, 16'd0);

		// fill the whole bin table, then hit a full table and oversize together
		wait_drained();
		@(negedge clk);
		queue_item(FUNC_RESTART, 16'd0);
		repeat (NUM_BINS) queue_item(FUNC_PLACE, 16'd1);
		queue_item(FUNC_PLACE, 16'd0);
		queue_item(FUNC_PLACE, 16'd1);
		queue_item(FUNC_PLACE, 16'd2);

		caps = '{1, 65535, 100, 7, 0, 250, 65535, 1000};
		caps[4] = $urandom_range(65535, 1);
		for (p = 0; p < 8; p++) begin
			write_capacity(size_t'(caps[p]));
			if (p == 3)
				calm = 1'b1;
			if (p == 1)
				stall_req = 1'b1;
			pack_sorted_run(caps[p], 40);
			@(negedge clk);
			stall_req = 1'b0;
			wait_drained();
			@(negedge clk);
			calm = 1'b0;
		end

		wait_drained();
		if (errors == 0)
			$display("PASS best_fit_bin_placement_top");
		else
			$display("FAIL best_fit_bin_placement_top");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/bfb_pkg.sv
hdl/bfb_ram.sv
hdl/best_fit_bin_placement_top.sv
hdl/bfb_checker.sv
verif/tb.sv
